### rtl/plre_pkg.sv
// ----------------------------------------------------------------------------
// Power-law rate evaluator package
// Shared widths, status and class codes, the pipeline control struct and
// the helper functions used by the evaluator and its cells.
// ----------------------------------------------------------------------------
package plre_pkg;

   localparam int PRESSURE_BITS      = 32;
   localparam int RATE_BITS          = 32;
   localparam int PRESSURE_CFG_BITS  = 31;
   localparam int EXPONENT_BITS      = 20;
   localparam int EXPONENT_FRAC      = 16;
   localparam int CSR_INDEX_BITS     = 3;

   // log2 values: integer part plus LOG_FRAC fraction bits
   localparam int LOG_FRAC           = 30;
   localparam int LOG_INT_BITS       = 5;
   localparam int LOG_BITS           = LOG_INT_BITS + LOG_FRAC;
   localparam int LOG_STEPS          = LOG_FRAC;

   // Q1.62 arithmetic
   localparam int WORD_BITS          = 64;
   localparam int HALF_BITS          = WORD_BITS / 2;
   localparam int Q_FRAC             = 62;
   localparam int MANT_BITS          = Q_FRAC + 1;
   localparam int SHIFT_BITS         = 6;
   localparam logic [WORD_BITS-1:0] LN2_Q62 = 64'h2C5C_85FD_F473_DE6A;
   localparam logic [WORD_BITS-1:0] ONE_Q62 = 64'h4000_0000_0000_0000;

   // three log lanes: sample, reference pressure, reference rate
   localparam int LANES              = 3;
   localparam int LANE_SAMPLE        = 0;
   localparam int LANE_REF_P         = 1;
   localparam int LANE_REF_RATE      = 2;

   // series for 2^f; later terms are always zero
   localparam int EXP_TERMS          = 20;
   localparam int DIV_BITS           = $clog2(EXP_TERMS + 1);
   localparam int DIV_STAGES         = 8;
   localparam int DIV_STEPS          = WORD_BITS / DIV_STAGES;

   // quotient digits are found by multiplying with a scaled reciprocal
   localparam int RECIP_SHIFT        = 20;
   localparam int RECIP_BITS         = RECIP_SHIFT + 1;
   localparam int DIGIT_BITS         = DIV_BITS + DIV_STEPS;
   localparam int DIGIT_PROD_BITS    = DIGIT_BITS + RECIP_BITS;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REF_RATE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REF_P    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXPONENT = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAL_MIN  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAL_MAX  = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DOMAIN  = 2'd1;
   localparam logic [1:0] ST_NUMERIC = 2'd2;

   // how a word is to be answered
   localparam logic [1:0] KIND_CALC   = 2'd0;
   localparam logic [1:0] KIND_DOMAIN = 2'd1;
   localparam logic [1:0] KIND_ZERO   = 2'd2;
   localparam logic [1:0] KIND_EQUAL  = 2'd3;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic       outcal;
      logic       numfail;
   } ctl_type;

   function automatic logic [LOG_INT_BITS-1:0] lead_one(input logic [RATE_BITS-1:0] x);
      logic [LOG_INT_BITS-1:0] n;
      n = '0;
      for (int i = 0; i < RATE_BITS; i++) begin
         if (x[i]) begin
            n = LOG_INT_BITS'(i);
         end
      end
      return n;
   endfunction

   // ceil(2^RECIP_SHIFT / n) for each term number of the series
   function automatic logic [RECIP_BITS-1:0] reciprocal(input logic [DIV_BITS-1:0] n);
      logic [RECIP_BITS-1:0] r;
      case (n)
         DIV_BITS'(1):  r = RECIP_BITS'(1048576);
         DIV_BITS'(2):  r = RECIP_BITS'(524288);
         DIV_BITS'(3):  r = RECIP_BITS'(349526);
         DIV_BITS'(4):  r = RECIP_BITS'(262144);
         DIV_BITS'(5):  r = RECIP_BITS'(209716);
         DIV_BITS'(6):  r = RECIP_BITS'(174763);
         DIV_BITS'(7):  r = RECIP_BITS'(149797);
         DIV_BITS'(8):  r = RECIP_BITS'(131072);
         DIV_BITS'(9):  r = RECIP_BITS'(116509);
         DIV_BITS'(10): r = RECIP_BITS'(104858);
         DIV_BITS'(11): r = RECIP_BITS'(95326);
         DIV_BITS'(12): r = RECIP_BITS'(87382);
         DIV_BITS'(13): r = RECIP_BITS'(80660);
         DIV_BITS'(14): r = RECIP_BITS'(74899);
         DIV_BITS'(15): r = RECIP_BITS'(69906);
         DIV_BITS'(16): r = RECIP_BITS'(65536);
         DIV_BITS'(17): r = RECIP_BITS'(61681);
         DIV_BITS'(18): r = RECIP_BITS'(58255);
         DIV_BITS'(19): r = RECIP_BITS'(55189);
         DIV_BITS'(20): r = RECIP_BITS'(52429);
         default:       r = '0;
      endcase
      return r;
   endfunction

endpackage

### rtl/power_law_rate_evaluator_core.sv
// ----------------------------------------------------------------------------
// Power-law rate evaluator
// Pipelined rate = reference_rate * (p / reference_pressure) ^ exponent,
// worked in base-2 log and exp fixed point.
// ----------------------------------------------------------------------------
// Usage
// A pressure word enters on the req_ stream and one result word leaves on
// the rsp_ stream for every word taken, in order. The rate is on rsp_tdata;
// rsp_tuser carries the status code and the out-of-calibration flag.
// The five registers are written through the csr_ port, one per cycle with
// csr_wen high; they may only be changed while no word is in flight.
// The block takes one word per cycle unless the pipeline is frozen by a
// stalled receiver. The datapath is a chain of cells: one Q62 squaring
// per log2 fraction bit and one series term per exp cell, each exp cell
// being mostly the eight-stage division by the term number.
// Reset is synchronous; it empties the pipeline and loads the register
// defaults. When the receiver stalls the finished word is held in the
// output register and the pipeline keeps moving and taking words as long
// as its last stage holds a bubble; it freezes only once a second finished
// word would collide with the one waiting.
// ----------------------------------------------------------------------------
module power_law_rate_evaluator_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream; tdata: pressure_sample[31:0]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [plre_pkg::PRESSURE_BITS-1:0]   req_tdata,
   // response stream; tdata: rate_value[31:0]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [plre_pkg::RATE_BITS-1:0]       rsp_tdata,
   // tuser: status_code[1:0], outside_calibration[2]
   output logic [2:0]                           rsp_tuser,
   // register write port
   input  logic                                 csr_wen,
   input  logic [plre_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [plre_pkg::RATE_BITS-1:0]       csr_wdata
);
   import plre_pkg::*;

   localparam int DIFF_BITS = LOG_BITS + 1;
   localparam int PROD_BITS = LOG_BITS + EXPONENT_BITS;
   localparam int Q_BITS    = PROD_BITS + 1 - EXPONENT_FRAC;
   localparam int L_BITS    = Q_BITS + 2;
   localparam int SUM_BITS  = WORD_BITS + 1;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [RATE_BITS-1:0]         ref_rate_ff;
   logic [PRESSURE_CFG_BITS-1:0] ref_p_ff, cal_min_ff, cal_max_ff;
   logic [EXPONENT_BITS-1:0]     exponent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_rate_ff <= 32'd16777216;
         ref_p_ff    <= 31'd1000000;
         exponent_ff <= 20'd65536;
         cal_min_ff  <= 31'd1;
         cal_max_ff  <= 31'h7FFF_FFFF;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_REF_RATE: ref_rate_ff <= csr_wdata;
            CSR_REF_P:    ref_p_ff    <= csr_wdata[PRESSURE_CFG_BITS-1:0];
            CSR_EXPONENT: exponent_ff <= csr_wdata[EXPONENT_BITS-1:0];
            CSR_CAL_MIN:  cal_min_ff  <= csr_wdata[PRESSURE_CFG_BITS-1:0];
            CSR_CAL_MAX:  cal_max_ff  <= csr_wdata[PRESSURE_CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Flow control. Every stage moves together; the pipeline only stops
   // when its last stage holds a word and the output register is full
   // and not being emptied.
   // ------------------------------------------------------------------
   logic    adv;
   logic    out_load;
   ctl_type ctl_r_ff;
   logic    rsp_tvalid_ff;

   assign out_load   = !rsp_tvalid_ff || rsp_tready;
   assign adv        = out_load || !ctl_r_ff.valid;
   assign req_tready = adv;

   // ------------------------------------------------------------------
   // Entry stage: classify the sample and normalise the three log lanes
   // ------------------------------------------------------------------
   logic [PRESSURE_CFG_BITS-1:0]   p;
   logic                           bad_cfg;
   ctl_type                        ctl_0_in;
   logic [LANES-1:0][RATE_BITS-1:0] lane_x;
   logic [LANES-1:0][MANT_BITS-1:0] mant_0_in;
   logic [LANES-1:0][LOG_BITS-1:0]  acc_0_in;

   assign p = req_tdata[PRESSURE_CFG_BITS-1:0];

   assign bad_cfg = (ref_rate_ff == '0) || (ref_p_ff == '0) || (exponent_ff == '0)
                 || (cal_min_ff == '0) || (cal_max_ff <= cal_min_ff)
                 || (ref_p_ff < cal_min_ff) || (ref_p_ff > cal_max_ff);

   always_comb begin
      ctl_0_in.valid   = req_tvalid;
      ctl_0_in.outcal  = (p < cal_min_ff) || (p > cal_max_ff);
      ctl_0_in.numfail = 1'b0;
      if (bad_cfg || req_tdata[PRESSURE_BITS-1]) begin
         ctl_0_in.kind = KIND_DOMAIN;
      end else if (p == '0) begin
         ctl_0_in.kind = KIND_ZERO;
      end else if (p == ref_p_ff) begin
         ctl_0_in.kind = KIND_EQUAL;
      end else begin
         ctl_0_in.kind = KIND_CALC;
      end
   end

   assign lane_x[LANE_SAMPLE]    = {1'b0, p};
   assign lane_x[LANE_REF_P]     = {1'b0, ref_p_ff};
   assign lane_x[LANE_REF_RATE]  = ref_rate_ff;

   // The leading one gives the integer part of the log; the mantissa is
   // moved up so that it reads as a Q1.62 value in [1, 2).
   for (genvar l = 0; l < LANES; l++) begin : g_norm
      logic [LOG_INT_BITS-1:0] n;
      assign n            = lead_one(lane_x[l]);
      assign mant_0_in[l] = MANT_BITS'({{(MANT_BITS-RATE_BITS){1'b0}}, lane_x[l]}
                            << (SHIFT_BITS'(Q_FRAC) - SHIFT_BITS'(n)));
      assign acc_0_in[l]  = LOG_BITS'(n);
   end

   ctl_type                          ctl_chain  [LOG_STEPS+1];
   logic [LANES-1:0][MANT_BITS-1:0]  mant_chain [LOG_STEPS+1];
   logic [LANES-1:0][LOG_BITS-1:0]   acc_chain  [LOG_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_chain[0] <= '0;
      end else if (adv) begin
         ctl_chain[0] <= ctl_0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mant_chain[0] <= mant_0_in;
         acc_chain[0]  <= acc_0_in;
      end
   end

   // ------------------------------------------------------------------
   // Log2 chain: one cell per fraction bit
   // ------------------------------------------------------------------
   for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
      plre_log_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .ctl_in   (ctl_chain[i]),
         .mant_in  (mant_chain[i]),
         .acc_in   (acc_chain[i]),
         .ctl_out  (ctl_chain[i+1]),
         .mant_out (mant_chain[i+1]),
         .acc_out  (acc_chain[i+1])
      );
   end

   // ------------------------------------------------------------------
   // Scale the log ratio by the exponent and add log2 of the reference
   // rate. The scaled term is rounded half away from zero.
   // ------------------------------------------------------------------
   logic [DIFF_BITS-1:0] diff;
   ctl_type              ctl_1_ff, ctl_2_ff, ctl_3_ff;
   logic                 neg_1_ff, neg_2_ff;
   logic [LOG_BITS-1:0]  mag_1_ff, lrr_1_ff, lrr_2_ff;
   logic [PROD_BITS-1:0] prod_2_ff;

   assign diff = {1'b0, acc_chain[LOG_STEPS][LANE_SAMPLE]}
               - {1'b0, acc_chain[LOG_STEPS][LANE_REF_P]};

   logic [Q_BITS-1:0]     q;
   logic [L_BITS-1:0]     lsum;
   logic [L_BITS-1:0]     lbias;
   logic                  range_fail;
   ctl_type               ctl_3_in;
   logic [SHIFT_BITS-1:0] shift_3_ff;
   logic [LOG_FRAC-1:0]   frac_3_ff;

   assign q = Q_BITS'(({1'b0, prod_2_ff} + (PROD_BITS+1)'(1 << (EXPONENT_FRAC - 1)))
                      >> EXPONENT_FRAC);

   assign lsum = neg_2_ff ? (L_BITS'(lrr_2_ff) - L_BITS'(q))
                          : (L_BITS'(lrr_2_ff) + L_BITS'(q));

   // Outside [-1, 32) in log terms the rate cannot be represented.
   assign range_fail = ($signed(lsum) >= $signed(L_BITS'(32) << LOG_FRAC))
                    || ($signed(lsum) < -$signed(L_BITS'(1) << LOG_FRAC));

   assign lbias = lsum + (L_BITS'(1) << LOG_FRAC);

   always_comb begin
      ctl_3_in         = ctl_2_ff;
      ctl_3_in.numfail = range_fail;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_1_ff <= '0;
         ctl_2_ff <= '0;
         ctl_3_ff <= '0;
      end else if (adv) begin
         ctl_1_ff <= ctl_chain[LOG_STEPS];
         ctl_2_ff <= ctl_1_ff;
         ctl_3_ff <= ctl_3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg_1_ff   <= diff[DIFF_BITS-1];
         mag_1_ff   <= diff[DIFF_BITS-1] ? LOG_BITS'(-diff) : diff[LOG_BITS-1:0];
         lrr_1_ff   <= acc_chain[LOG_STEPS][LANE_REF_RATE];
         neg_2_ff   <= neg_1_ff;
         prod_2_ff  <= PROD_BITS'(mag_1_ff) * PROD_BITS'(exponent_ff);
         lrr_2_ff   <= lrr_1_ff;
         // the right shift that ends the exp is 63 minus the biased integer part
         shift_3_ff <= SHIFT_BITS'(Q_FRAC + 1) - SHIFT_BITS'(lbias[LOG_BITS:LOG_FRAC]);
         frac_3_ff  <= lbias[LOG_FRAC-1:0];
      end
   end

   // ------------------------------------------------------------------
   // x = f * ln2 in Q62, then the seed of the series
   // ------------------------------------------------------------------
   logic [WORD_BITS-1:0]  x_prod;
   ctl_type               ctl_xa_ff;
   logic [SHIFT_BITS-1:0] shift_xa_ff;

   plre_mul_q62 u_ln2 (
      .clock   (clock),
      .adv     (adv),
      .op_a    ({2'b00, frac_3_ff, {HALF_BITS{1'b0}}}),
      .op_b    (LN2_Q62),
      .product (x_prod)
   );

   ctl_type               ctl_e   [EXP_TERMS+1];
   logic [SHIFT_BITS-1:0] shift_e [EXP_TERMS+1];
   logic [WORD_BITS-1:0]  x_e     [EXP_TERMS+1];
   logic [WORD_BITS-1:0]  y_e     [EXP_TERMS+1];
   logic [WORD_BITS-1:0]  term_e  [EXP_TERMS+1];

   ctl_type               ctl_x_ff;
   logic [SHIFT_BITS-1:0] shift_x_ff;
   logic [WORD_BITS-1:0]  x_x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_xa_ff <= '0;
         ctl_x_ff  <= '0;
      end else if (adv) begin
         ctl_xa_ff <= ctl_3_ff;
         ctl_x_ff  <= ctl_xa_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         shift_xa_ff <= shift_3_ff;
         shift_x_ff  <= shift_xa_ff;
         x_x_ff      <= x_prod;
      end
   end

   assign ctl_e[0]   = ctl_x_ff;
   assign shift_e[0] = shift_x_ff;
   assign x_e[0]     = x_x_ff;
   assign y_e[0]     = ONE_Q62;
   assign term_e[0]  = ONE_Q62;

   // ------------------------------------------------------------------
   // Series chain: cell n adds x^n / n! (each product and quotient
   // truncated). Terms past the last cell are zero for any f < 1.
   // ------------------------------------------------------------------
   for (genvar i = 0; i < EXP_TERMS; i++) begin : g_exp
      plre_exp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .divisor   (DIV_BITS'(i + 1)),
         .ctl_in    (ctl_e[i]),
         .shift_in  (shift_e[i]),
         .x_in      (x_e[i]),
         .y_in      (y_e[i]),
         .term_in   (term_e[i]),
         .ctl_out   (ctl_e[i+1]),
         .shift_out (shift_e[i+1]),
         .x_out     (x_e[i+1]),
         .y_out     (y_e[i+1]),
         .term_out  (term_e[i+1])
      );
   end

   // ------------------------------------------------------------------
   // Round half up to the output scale, then pick the answer by class
   // ------------------------------------------------------------------
   logic [SUM_BITS-1:0]   sum_r_ff;
   logic [SHIFT_BITS-1:0] shift_r_ff;
   logic [SUM_BITS-1:0]   rate_full;
   logic                  rate_fail;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_r_ff <= '0;
      end else if (adv) begin
         ctl_r_ff <= ctl_e[EXP_TERMS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_r_ff   <= SUM_BITS'(y_e[EXP_TERMS])
                     + (SUM_BITS'(1) << (shift_e[EXP_TERMS] - SHIFT_BITS'(1)));
         shift_r_ff <= shift_e[EXP_TERMS];
      end
   end

   assign rate_full = sum_r_ff >> shift_r_ff;
   assign rate_fail = ctl_r_ff.numfail || (rate_full == '0)
                   || (rate_full[SUM_BITS-1:RATE_BITS] != '0);

   logic [RATE_BITS-1:0] rate_in, rate_ff;
   logic [1:0]           status_in, status_ff;
   logic                 outcal_in, outcal_ff;

   always_comb begin
      rate_in   = '0;
      status_in = ST_OK;
      outcal_in = 1'b0;
      case (ctl_r_ff.kind)
         KIND_DOMAIN: begin
            status_in = ST_DOMAIN;
         end
         KIND_ZERO: begin
            outcal_in = 1'b1;
         end
         KIND_EQUAL: begin
            rate_in = ref_rate_ff;
         end
         KIND_CALC: begin
            if (rate_fail) begin
               status_in = ST_NUMERIC;
            end else begin
               rate_in   = rate_full[RATE_BITS-1:0];
               outcal_in = ctl_r_ff.outcal;
            end
         end
         default: begin
            status_in = ST_DOMAIN;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_tvalid_ff <= ctl_r_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rate_ff   <= rate_in;
         status_ff <= status_in;
         outcal_ff <= outcal_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rate_ff;
   assign rsp_tuser  = {outcal_ff, status_ff};

endmodule

### rtl/plre_mul_q62.sv
// ----------------------------------------------------------------------------
// Q62 multiplier
// Registers four 32 by 32 partial products, then sums them and returns
// floor(a * b / 2^62) from the registered partials.
// ----------------------------------------------------------------------------
module plre_mul_q62 (
   input  logic                           clock,
   input  logic                           adv,
   input  logic [plre_pkg::WORD_BITS-1:0] op_a,
   input  logic [plre_pkg::WORD_BITS-1:0] op_b,
   output logic [plre_pkg::WORD_BITS-1:0] product
);
   import plre_pkg::*;

   logic [WORD_BITS-1:0]   p00_ff, p01_ff, p10_ff, p11_ff;
   logic [2*WORD_BITS-1:0] sum;

   always_ff @(posedge clock) begin
      if (adv) begin
         p00_ff <= WORD_BITS'(op_a[HALF_BITS-1:0]) * WORD_BITS'(op_b[HALF_BITS-1:0]);
         p01_ff <= WORD_BITS'(op_a[HALF_BITS-1:0]) * WORD_BITS'(op_b[WORD_BITS-1:HALF_BITS]);
         p10_ff <= WORD_BITS'(op_a[WORD_BITS-1:HALF_BITS]) * WORD_BITS'(op_b[HALF_BITS-1:0]);
         p11_ff <= WORD_BITS'(op_a[WORD_BITS-1:HALF_BITS])
                   * WORD_BITS'(op_b[WORD_BITS-1:HALF_BITS]);
      end
   end

   assign sum = {p11_ff, {WORD_BITS{1'b0}}}
              + {{HALF_BITS{1'b0}}, p10_ff, {HALF_BITS{1'b0}}}
              + {{HALF_BITS{1'b0}}, p01_ff, {HALF_BITS{1'b0}}}
              + {{WORD_BITS{1'b0}}, p00_ff};

   assign product = sum[Q_FRAC+WORD_BITS-1:Q_FRAC];

endmodule

### rtl/plre_log_cell.sv
// ----------------------------------------------------------------------------
// Log2 cell
// One squaring step of the log2 mantissa for all lanes: square, test
// against two, halve if needed and shift one fraction bit into the log.
// ----------------------------------------------------------------------------
module plre_log_cell (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  logic                                                    adv,
   input  plre_pkg::ctl_type                                       ctl_in,
   input  logic [plre_pkg::LANES-1:0][plre_pkg::MANT_BITS-1:0]     mant_in,
   input  logic [plre_pkg::LANES-1:0][plre_pkg::LOG_BITS-1:0]      acc_in,
   output plre_pkg::ctl_type                                       ctl_out,
   output logic [plre_pkg::LANES-1:0][plre_pkg::MANT_BITS-1:0]     mant_out,
   output logic [plre_pkg::LANES-1:0][plre_pkg::LOG_BITS-1:0]      acc_out
);
   import plre_pkg::*;

   ctl_type                              ctl_a_ff, ctl_b_ff;
   logic [LANES-1:0][LOG_BITS-1:0]       acc_a_ff, acc_b_ff, acc_b_in;
   logic [LANES-1:0][MANT_BITS-1:0]      mant_b_ff, mant_b_in;
   logic [LANES-1:0][WORD_BITS-1:0]      square;

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      plre_mul_q62 u_sq (
         .clock   (clock),
         .adv     (adv),
         .op_a    ({1'b0, mant_in[l]}),
         .op_b    ({1'b0, mant_in[l]}),
         .product (square[l])
      );

      // a square of two or more gives a one bit and is halved
      always_comb begin
         if (square[l][WORD_BITS-1]) begin
            mant_b_in[l] = square[l][WORD_BITS-1:1];
         end else begin
            mant_b_in[l] = square[l][MANT_BITS-1:0];
         end
         acc_b_in[l] = {acc_a_ff[l][LOG_BITS-2:0], square[l][WORD_BITS-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
      end else if (adv) begin
         ctl_a_ff <= ctl_in;
         ctl_b_ff <= ctl_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         acc_a_ff  <= acc_in;
         acc_b_ff  <= acc_b_in;
         mant_b_ff <= mant_b_in;
      end
   end

   assign ctl_out  = ctl_b_ff;
   assign mant_out = mant_b_ff;
   assign acc_out  = acc_b_ff;

endmodule

### rtl/plre_exp_cell.sv
// ----------------------------------------------------------------------------
// Series cell
// One term of the 2^f series: term * x in Q62, divided by the term number
// eight quotient bits a stage, then added to the running sum.
// ----------------------------------------------------------------------------
module plre_exp_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic [plre_pkg::DIV_BITS-1:0]   divisor,
   input  plre_pkg::ctl_type               ctl_in,
   input  logic [plre_pkg::SHIFT_BITS-1:0] shift_in,
   input  logic [plre_pkg::WORD_BITS-1:0]  x_in,
   input  logic [plre_pkg::WORD_BITS-1:0]  y_in,
   input  logic [plre_pkg::WORD_BITS-1:0]  term_in,
   output plre_pkg::ctl_type               ctl_out,
   output logic [plre_pkg::SHIFT_BITS-1:0] shift_out,
   output logic [plre_pkg::WORD_BITS-1:0]  x_out,
   output logic [plre_pkg::WORD_BITS-1:0]  y_out,
   output logic [plre_pkg::WORD_BITS-1:0]  term_out
);
   import plre_pkg::*;

   // One quotient digit of DIV_STEPS bits. The partial remainder stays
   // below the divisor, so the digit is exact from the scaled reciprocal.
   function automatic logic [DIV_BITS+WORD_BITS-1:0] div_steps(
      input logic [WORD_BITS-1:0]  work,
      input logic [DIV_BITS-1:0]   rem,
      input logic [DIV_BITS-1:0]   dv,
      input logic [RECIP_BITS-1:0] recip
   );
      logic [DIGIT_BITS-1:0]      v;
      logic [DIGIT_PROD_BITS-1:0] prod;
      logic [DIV_STEPS-1:0]       qd;
      logic [DIGIT_BITS-1:0]      back;
      v    = {rem, work[WORD_BITS-1 -: DIV_STEPS]};
      prod = DIGIT_PROD_BITS'(v) * DIGIT_PROD_BITS'(recip);
      qd   = prod[RECIP_SHIFT +: DIV_STEPS];
      back = v - DIGIT_BITS'(DIGIT_BITS'(qd) * DIGIT_BITS'(dv));
      return {back[DIV_BITS-1:0], work[WORD_BITS-DIV_STEPS-1:0], qd};
   endfunction

   logic [WORD_BITS-1:0]  product;
   logic [RECIP_BITS-1:0] recip;

   ctl_type               ctl_a_ff;
   logic [SHIFT_BITS-1:0] shift_a_ff;
   logic [WORD_BITS-1:0]  x_a_ff, y_a_ff;

   // stage 0 of these arrays is the product stage, then one per division stage
   ctl_type               ctl_d_ff   [DIV_STAGES+1];
   logic [SHIFT_BITS-1:0] shift_d_ff [DIV_STAGES+1];
   logic [WORD_BITS-1:0]  x_d_ff     [DIV_STAGES+1];
   logic [WORD_BITS-1:0]  y_d_ff     [DIV_STAGES+1];
   logic [WORD_BITS-1:0]  work_d_ff  [DIV_STAGES+1];
   logic [DIV_BITS-1:0]   rem_d_ff   [DIV_STAGES+1];

   ctl_type               ctl_s_ff;
   logic [SHIFT_BITS-1:0] shift_s_ff;
   logic [WORD_BITS-1:0]  x_s_ff, y_s_ff, term_s_ff;

   assign recip = reciprocal(divisor);

   plre_mul_q62 u_mul (
      .clock   (clock),
      .adv     (adv),
      .op_a    (term_in),
      .op_b    (x_in),
      .product (product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff    <= '0;
         ctl_d_ff[0] <= '0;
      end else if (adv) begin
         ctl_a_ff    <= ctl_in;
         ctl_d_ff[0] <= ctl_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         shift_a_ff    <= shift_in;
         x_a_ff        <= x_in;
         y_a_ff        <= y_in;
         shift_d_ff[0] <= shift_a_ff;
         x_d_ff[0]     <= x_a_ff;
         y_d_ff[0]     <= y_a_ff;
         work_d_ff[0]  <= product;
         rem_d_ff[0]   <= '0;
      end
   end

   for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
      logic [DIV_BITS+WORD_BITS-1:0] step;

      assign step = div_steps(work_d_ff[s-1], rem_d_ff[s-1], divisor, recip);

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_d_ff[s] <= '0;
         end else if (adv) begin
            ctl_d_ff[s] <= ctl_d_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            shift_d_ff[s] <= shift_d_ff[s-1];
            x_d_ff[s]     <= x_d_ff[s-1];
            y_d_ff[s]     <= y_d_ff[s-1];
            work_d_ff[s]  <= step[WORD_BITS-1:0];
            rem_d_ff[s]   <= step[DIV_BITS+WORD_BITS-1:WORD_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s_ff <= '0;
      end else if (adv) begin
         ctl_s_ff <= ctl_d_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         shift_s_ff <= shift_d_ff[DIV_STAGES];
         x_s_ff     <= x_d_ff[DIV_STAGES];
         y_s_ff     <= y_d_ff[DIV_STAGES] + work_d_ff[DIV_STAGES];
         term_s_ff  <= work_d_ff[DIV_STAGES];
      end
   end

   assign ctl_out   = ctl_s_ff;
   assign shift_out = shift_s_ff;
   assign x_out     = x_s_ff;
   assign y_out     = y_s_ff;
   assign term_out  = term_s_ff;

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Power-law rate evaluator testbench
// Drives pressure words through the evaluator under a series of register
// settings and checks every result against a bit-level predictor of the
// log2/exp2 datapath, with random gaps on both streams.
// ----------------------------------------------------------------------------
module testbench;
   import plre_pkg::*;

   typedef struct packed {
      logic [31:0] rate;
      logic [1:0]  status;
      logic        outcal;
   } rate_result_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 320;
   localparam int RATE_TOLERANCE = 2;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [PRESSURE_BITS-1:0]  req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RATE_BITS-1:0]      rsp_tdata;
   logic [2:0]                rsp_tuser;
   logic                      csr_wen;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [RATE_BITS-1:0]      csr_wdata;

   // Shadow copy of the five registers, updated as they are written.
   logic [31:0] shadow_rate;
   logic [30:0] shadow_refp;
   logic [19:0] shadow_exp;
   logic [30:0] shadow_min;
   logic [30:0] shadow_max;

   logic [31:0]     pressure_words[$];
   rate_result_type expected_rates[$];
   int              failures;
   int              quiet_cycles;
   int              send_gap;
   int              recv_stall;
   bit              gaps_enabled;

   power_law_rate_evaluator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // floor(a * b / 2^62), kept to 64 bits as the datapath does.
   function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // log2 of a positive integer with 30 fraction bits, formed by repeated
   // squaring of the normalised mantissa.
   function automatic longint log2_q30(input logic [63:0] x);
      int          n;
      logic [63:0] m;
      longint      r;
      n = 0;
      while (n < 62 && (x >> (n + 1)) != 0) n++;
      m = x << (62 - n);
      r = longint'(n) <<< 30;
      for (int i = 29; i >= 0; i--) begin
         m = q62_product(m, m);
         if (m[63]) begin
            m = m >> 1;
            r = r + (longint'(1) <<< i);
         end
      end
      return r;
   endfunction

   // Expected answer for one pressure word under the shadow registers.
   function automatic rate_result_type predict_rate(input logic [31:0] sample);
      rate_result_type res;
      longint          d, t, lsum;
      logic [63:0]     mag, q, u, f, x, y, term, r;
      int              k, s;
      res = '{rate: 32'd0, status: ST_OK, outcal: 1'b0};
      if (shadow_rate == 0 || shadow_refp == 0 || shadow_exp == 0 || shadow_min == 0 ||
          shadow_max <= shadow_min || shadow_refp < shadow_min || shadow_refp > shadow_max) begin
         res.status = ST_DOMAIN;
         return res;
      end
      if (sample[31]) begin
         res.status = ST_DOMAIN;
         return res;
      end
      if (sample == 0) begin
         res.outcal = 1'b1;
         return res;
      end
      if (sample == {1'b0, shadow_refp}) begin
         res.rate = shadow_rate;
         return res;
      end
      d    = log2_q30({32'd0, sample}) - log2_q30({33'd0, shadow_refp});
      mag  = (d < 0) ? 64'(-d) : 64'(d);
      q    = (mag * {44'd0, shadow_exp} + 64'd32768) >> 16;
      t    = (d < 0) ? -longint'(q) : longint'(q);
      lsum = log2_q30({32'd0, shadow_rate}) + t;
      if (lsum >= (longint'(32) <<< 30) || lsum < -(longint'(1) <<< 30)) begin
         res.status = ST_NUMERIC;
         return res;
      end
      u = 64'(lsum + (longint'(1) <<< 30));
      k = int'(u >> 30) - 1;
      f = u & 64'h3FFF_FFFF;
      // 2^f as a truncated Taylor series of e^(f ln2)
      x    = q62_product(f << 32, LN2_Q62);
      y    = ONE_Q62;
      term = y;
      for (int n = 1; n <= 40; n++) begin
         term = q62_product(term, x) / 64'(n);
         if (term == 0) break;
         y = y + term;
      end
      s = 62 - k;
      r = (y + (64'd1 << (s - 1))) >> s;
      if (r == 0 || r > 64'hFFFF_FFFF) begin
         res.status = ST_NUMERIC;
         return res;
      end
      res.rate = r[31:0];
      if (sample < {1'b0, shadow_min} || sample > {1'b0, shadow_max}) res.outcal = 1'b1;
      return res;
   endfunction

   // Request driver: one word at a time from the pending queue, with a
   // random gap (when gaps are enabled) drawn as each word is presented.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pressure_words.size() > 0) begin
            req_tdata  <= pressure_words.pop_front();
            req_tvalid <= 1'b1;
            send_gap   <= gaps_enabled ? $urandom_range(0, 5) : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure: after each result, stall for a random count.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         recv_stall = gaps_enabled ? $urandom_range(0, 5) : 0;
         rsp_tready <= (recv_stall == 0);
      end else if (recv_stall > 0) begin
         recv_stall = recv_stall - 1;
         rsp_tready <= (recv_stall == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predict on every accepted request word, check every accepted
   // result word against the oldest prediction.
   always @(posedge clock) begin
      rate_result_type want;
      int              diff;
      if (!reset) begin
         if (req_tvalid && req_tready) expected_rates.push_back(predict_rate(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rates.size() == 0) begin
               $error("unexpected result word: rate %0d status %0d", rsp_tdata, rsp_tuser[1:0]);
               failures++;
            end else begin
               want = expected_rates.pop_front();
               if (rsp_tuser[1:0] !== want.status) begin
                  $error("status_code: expected %0d, actual %0d", want.status, rsp_tuser[1:0]);
                  failures++;
               end
               if (rsp_tuser[2] !== want.outcal) begin
                  $error("outside_calibration: expected %0d, actual %0d",
                         want.outcal, rsp_tuser[2]);
                  failures++;
               end
               // A successful rate may differ by a couple of LSBs; failures
               // must read exactly zero.
               diff = int'(rsp_tdata) - int'(want.rate);
               if ($isunknown(rsp_tdata) ||
                   (want.status == ST_OK && rsp_tuser[1:0] == ST_OK ?
                    (diff > RATE_TOLERANCE || diff < -RATE_TOLERANCE) :
                    rsp_tdata !== want.rate)) begin
                  $error("rate_value: expected %0d, actual %0d", want.rate, rsp_tdata);
                  failures++;
               end
            end
         end
      end
   end

   // Watchdog: any handshake or register write resets the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** power_law_rate_evaluator_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Blocks until every queued word has been sent and answered. The check
   // sits on the falling edge so that the driver and monitor have settled.
   task automatic wait_drained();
      do @(negedge clock);
      while (pressure_words.size() > 0 || req_tvalid || expected_rates.size() > 0);
   endtask

   // Writes all five registers on consecutive cycles and mirrors them.
   task automatic program_registers(input logic [31:0] rate, input logic [31:0] refp,
                                    input logic [31:0] expo, input logic [31:0] cmin,
                                    input logic [31:0] cmax);
      logic [31:0] vals[5];
      vals = '{rate, refp, expo, cmin, cmax};
      for (int i = 0; i < 5; i++) begin
         @(posedge clock);
         csr_wen   <= 1'b1;
         csr_index <= CSR_INDEX_BITS'(i);
         csr_wdata <= vals[i];
      end
      @(posedge clock);
      csr_wen     <= 1'b0;
      shadow_rate = rate;
      shadow_refp = refp[30:0];
      shadow_exp  = expo[19:0];
      shadow_min  = cmin[30:0];
      shadow_max  = cmax[30:0];
   endtask

   // A sample drawn to land near the interesting regions of the curve.
   function automatic logic [31:0] draw_pressure();
      longint v;
      case ($urandom_range(0, 6))
         0: v = $urandom;
         1: v = $urandom_range(shadow_min, shadow_max);
         2: v = longint'(shadow_refp) + $urandom_range(0, 64) - 32;
         3: v = longint'(shadow_refp) >> $urandom_range(0, 12);
         4: v = longint'(shadow_refp) << $urandom_range(0, 12);
         5: v = $urandom_range(0, 100);
         default: v = longint'(shadow_refp) * $urandom_range(50, 200) / 100;
      endcase
      if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
      return v[31:0];
   endfunction

   initial begin
      logic [31:0] cmin, cmax, refp, expo, rate;
      reset        = 1'b1;
      csr_wen      = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      failures     = 0;
      gaps_enabled = 1'b1;
      shadow_rate  = 32'd16777216;
      shadow_refp  = 31'd1000000;
      shadow_exp   = 20'd65536;
      shadow_min   = 31'd1;
      shadow_max   = 31'h7FFF_FFFF;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed words under the reset defaults: sign extremes, zero, the
      // reference pressure itself and its neighbours, and the top of range.
      pressure_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'd1, 32'd1000000, 32'd999999, 32'd1000001, 32'd2000000,
                         32'd500000, 32'd2, 32'h4000_0000};
      wait_drained();

      // Steep exponent and large rate: overflow above the reference, and
      // samples outside a narrow calibrated interval.
      program_registers(32'hFFFF_FFFF, 32'd1000, 32'hF_FFFF, 32'd500, 32'd2000);
      pressure_words = '{32'd1000, 32'd1001, 32'd999, 32'd100, 32'd3000, 32'd0, 32'd1};
      wait_drained();

      // Smallest rate and exponent: samples below, at and above the reference.
      program_registers(32'd1, 32'h7FFF_FFFE, 32'd1, 32'd1, 32'h7FFF_FFFF);
      pressure_words = '{32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'd12345};
      wait_drained();

      // Broken settings: max not above min, reference outside, a zero register.
      program_registers(32'd16777216, 32'd100, 32'd65536, 32'd100, 32'd100);
      pressure_words = '{32'd100, 32'd0};
      wait_drained();
      program_registers(32'd16777216, 32'd5000, 32'd65536, 32'd100, 32'd4000);
      pressure_words = '{32'd1000};
      wait_drained();
      program_registers(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      pressure_words = '{32'd1000};
      wait_drained();

      // Random phases: each a fresh, mostly valid setting with about eighty
      // words; some phases run without any gaps.
      for (int phase = 0; phase < 10; phase++) begin
         cmin = $urandom_range(1, 2000000);
         cmax = cmin + $urandom_range(1, 32'h4000_0000);
         refp = $urandom_range(cmin, cmax);
         expo = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32'hF_FFFF)
                                            : $urandom_range(1, 32'h3_FFFF);
         rate = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 32'hFFFF_FFFF)
                                            : $urandom_range(1 << 16, 1 << 28);
         if ($urandom_range(0, 9) == 0) cmax = cmin;
         program_registers(rate, refp, expo, cmin, cmax);
         gaps_enabled = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < 80; i++) pressure_words.push_back(draw_pressure());
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && expected_rates.size() == 0) begin
         $display("** power_law_rate_evaluator_core: PASSED **");
      end else begin
         $display("** power_law_rate_evaluator_core: FAILED **");
      end
      $finish;
   end

endmodule
